/* hdl/tfn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared widths and pipeline payload types for the face normal unit.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int CoordBits  = 16;
  localparam int NormFrac   = 14;
  localparam int OutBits    = 16;
  localparam int EdgeBits   = CoordBits + 1;            // 17
  localparam int CrossBits  = 2 * EdgeBits + 1;         // 35, signed
  localparam int MagBits    = CrossBits - 1;            // 34, unsigned magnitude
  localparam int SumBits    = 2 * MagBits + 2;          // 70
  localparam int LenBits    = SumBits / 2;              // 35
  localparam int NumBits    = MagBits + NormFrac + 1;   // 49
  localparam int SqrtSteps  = LenBits;                  // one result bit per cell
  localparam int DivSteps   = NormFrac + 2;             // quotient bits 15..0
  localparam int CfgBits    = 16;

  // payload carried from cell to cell
  typedef struct packed {
    logic [MagBits-1:0] mag_x;
    logic [MagBits-1:0] mag_y;
    logic [MagBits-1:0] mag_z;
    logic               neg_x;
    logic               neg_y;
    logic               neg_z;
    logic [SumBits-1:0] rem;     // square root remainder
    logic [LenBits-1:0] root;    // partial root
    logic [CfgBits-1:0] thr;     // threshold captured at entry
  } sqrt_word_t;

  typedef struct packed {
    logic [NumBits-1:0] num_x;
    logic [NumBits-1:0] num_y;
    logic [NumBits-1:0] num_z;
    logic [DivSteps-1:0] q_x;
    logic [DivSteps-1:0] q_y;
    logic [DivSteps-1:0] q_z;
    logic               neg_x;
    logic               neg_y;
    logic               neg_z;
    logic [LenBits-1:0] len;
    logic               degen;
  } div_word_t;

endpackage

/* hdl/tfn_sqrt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_sqrt_cell
// One restoring square root step; decides one root bit per cycle while en is high.
// ----------------------------------------------------------------------------
module tfn_sqrt_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [5:0]          bit_pos,
  input  logic                in_valid,
  input  tfn_pkg::sqrt_word_t in_word,
  output logic                out_valid,
  output tfn_pkg::sqrt_word_t out_word
);

  logic [tfn_pkg::SumBits-1:0] trial;
  logic [tfn_pkg::SumBits-1:0] root_w;
  tfn_pkg::sqrt_word_t         word_next;

  // trial = (2*root + 2^p) * 2^p = (root << (p+1)) + (1 << 2p)
  always_comb begin
    root_w    = {{(tfn_pkg::SumBits - tfn_pkg::LenBits){1'b0}}, in_word.root};
    trial     = (root_w << ({1'b0, bit_pos} + 7'd1))
              | ({{(tfn_pkg::SumBits-1){1'b0}}, 1'b1} << ({1'b0, bit_pos} + {1'b0, bit_pos}));
    word_next = in_word;
    if (in_word.rem >= trial) begin
      word_next.rem  = in_word.rem - trial;
      word_next.root = in_word.root | ({{(tfn_pkg::LenBits-1){1'b0}}, 1'b1} << bit_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule

/* hdl/tfn_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_div_cell
// One restoring division step for all three components at one quotient bit.
// ----------------------------------------------------------------------------
module tfn_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [4:0]         bit_pos,
  input  logic               in_valid,
  input  tfn_pkg::div_word_t in_word,
  output logic               out_valid,
  output tfn_pkg::div_word_t out_word
);

  localparam int W = tfn_pkg::NumBits + tfn_pkg::DivSteps;

  logic [W-1:0]        den_sh;
  tfn_pkg::div_word_t  word_next;

  // subtract len * 2^p from each numerator where it fits
  always_comb begin
    den_sh    = {{(W - tfn_pkg::LenBits){1'b0}}, in_word.len} << bit_pos;
    word_next = in_word;
    if ({{tfn_pkg::DivSteps{1'b0}}, in_word.num_x} >= den_sh) begin
      word_next.num_x = in_word.num_x - den_sh[tfn_pkg::NumBits-1:0];
      word_next.q_x[bit_pos[3:0]] = 1'b1;
    end
    if ({{tfn_pkg::DivSteps{1'b0}}, in_word.num_y} >= den_sh) begin
      word_next.num_y = in_word.num_y - den_sh[tfn_pkg::NumBits-1:0];
      word_next.q_y[bit_pos[3:0]] = 1'b1;
    end
    if ({{tfn_pkg::DivSteps{1'b0}}, in_word.num_z} >= den_sh) begin
      word_next.num_z = in_word.num_z - den_sh[tfn_pkg::NumBits-1:0];
      word_next.q_z[bit_pos[3:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule

/* hdl/triangle_face_normal_unit_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal_unit_core
// Unit face normal of a triangle through a chain of square root and divide
// cells.
// ----------------------------------------------------------------------------
// One triangle is taken and one result leaves per clock unless stalled. A
// triangle passes the front-end registers (edges, cross product, squares and
// sum), 35 square root cells, the threshold register, 16 divide cells and the
// output register. The whole chain stalls as one when the output register is
// full and not taken; the square root and divide cell rows set the latency.
module triangle_face_normal_unit_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data,       // min_length
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // normal_x, normal_y, normal_z, degenerate from bit 0 up, zero padded
  output logic [55:0]  m_axis_tdata
);

  localparam int EB = tfn_pkg::EdgeBits;
  localparam int CB = tfn_pkg::CrossBits;
  localparam int MB = tfn_pkg::MagBits;
  localparam int SB = tfn_pkg::SumBits;
  localparam int LB = tfn_pkg::LenBits;
  localparam int NB = tfn_pkg::NumBits;
  localparam int NS = tfn_pkg::SqrtSteps;
  localparam int ND = tfn_pkg::DivSteps;

  logic [15:0] min_length;
  logic        en;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= '0;
    end else if (cfg_valid) begin
      min_length <= cfg_data;
    end
  end

  // whole chain advances unless the output holds an untaken result
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: edges
  logic                 v1;
  logic signed [EB-1:0] e1 [3];
  logic signed [EB-1:0] e2 [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1[k] <= EB'($signed(s_axis_tdata[(3+k)*16 +: 16]))
               - EB'($signed(s_axis_tdata[k*16 +: 16]));
        e2[k] <= EB'($signed(s_axis_tdata[(6+k)*16 +: 16]))
               - EB'($signed(s_axis_tdata[k*16 +: 16]));
      end
    end
  end

  // stage 2: cross product
  logic                 v2;
  logic signed [CB-1:0] cr [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cr[0] <= CB'(e1[1] * e2[2]) - CB'(e1[2] * e2[1]);
      cr[1] <= CB'(e1[2] * e2[0]) - CB'(e1[0] * e2[2]);
      cr[2] <= CB'(e1[0] * e2[1]) - CB'(e1[1] * e2[0]);
    end
  end

  // stage 3: magnitudes, squares and sum into the first sqrt cell
  logic [MB-1:0] mg [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mg[k] = cr[k][CB-1] ? MB'(-cr[k]) : cr[k][MB-1:0];
    end
  end

  logic                v3;
  tfn_pkg::sqrt_word_t sw [NS+1];
  logic                sv [NS+1];
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sw[0].mag_x <= mg[0];
      sw[0].mag_y <= mg[1];
      sw[0].mag_z <= mg[2];
      sw[0].neg_x <= cr[0][CB-1];
      sw[0].neg_y <= cr[1][CB-1];
      sw[0].neg_z <= cr[2][CB-1];
      sw[0].rem   <= SB'({{MB{1'b0}}, mg[0]} * {{MB{1'b0}}, mg[0]})
                   + SB'({{MB{1'b0}}, mg[1]} * {{MB{1'b0}}, mg[1]})
                   + SB'({{MB{1'b0}}, mg[2]} * {{MB{1'b0}}, mg[2]});
      sw[0].root  <= '0;
      sw[0].thr   <= min_length;
    end
  end
  assign sv[0] = v3;

  // square root cell row, most significant root bit first
  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    tfn_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .bit_pos  (6'(NS - 1 - i)),
      .in_valid (sv[i]),
      .in_word  (sw[i]),
      .out_valid(sv[i+1]),
      .out_word (sw[i+1])
    );
  end

  // threshold check and rounded numerators
  tfn_pkg::div_word_t dw [ND+1];
  logic               dv [ND+1];
  logic [LB-1:0]      len_w;
  assign len_w = sw[NS].root;
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= sv[NS];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dw[0].num_x <= (NB'(sw[NS].mag_x) << tfn_pkg::NormFrac) + NB'(len_w >> 1);
      dw[0].num_y <= (NB'(sw[NS].mag_y) << tfn_pkg::NormFrac) + NB'(len_w >> 1);
      dw[0].num_z <= (NB'(sw[NS].mag_z) << tfn_pkg::NormFrac) + NB'(len_w >> 1);
      dw[0].q_x   <= '0;
      dw[0].q_y   <= '0;
      dw[0].q_z   <= '0;
      dw[0].neg_x <= sw[NS].neg_x;
      dw[0].neg_y <= sw[NS].neg_y;
      dw[0].neg_z <= sw[NS].neg_z;
      dw[0].len   <= len_w;
      dw[0].degen <= len_w <= LB'(sw[NS].thr);
    end
  end

  // divide cell row
  for (genvar j = 0; j < ND; j++) begin : g_div
    tfn_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .bit_pos  (5'(ND - 1 - j)),
      .in_valid (dv[j]),
      .in_word  (dw[j]),
      .out_valid(dv[j+1]),
      .out_word (dw[j+1])
    );
  end

  // saturate, sign and register the result
  localparam logic [ND-1:0] One = ND'(1) << tfn_pkg::NormFrac;
  logic [ND-1:0] qs [3];
  logic [15:0]   nr [3];
  always_comb begin
    qs[0] = (dw[ND].q_x > One) ? One : dw[ND].q_x;
    qs[1] = (dw[ND].q_y > One) ? One : dw[ND].q_y;
    qs[2] = (dw[ND].q_z > One) ? One : dw[ND].q_z;
    nr[0] = dw[ND].neg_x ? 16'(-qs[0]) : 16'(qs[0]);
    nr[1] = dw[ND].neg_y ? 16'(-qs[1]) : 16'(qs[1]);
    nr[2] = dw[ND].neg_z ? 16'(-qs[2]) : 16'(qs[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv[ND];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (dw[ND].degen) begin
        m_axis_tdata <= {7'd0, 1'b1, 48'd0};
      end else begin
        m_axis_tdata <= {7'd0, 1'b0, nr[2], nr[1], nr[0]};
      end
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the triangle face normal unit. A directed table of
// triangles (extremes, degenerate shapes, threshold edges) is followed by
// random triangles under several threshold settings and idling patterns. Known
// rows are checked to the table, the rest to an exact wide-integer model.
// ----------------------------------------------------------------------------
module tb;

  localparam int NDIR      = 14;
  localparam int NRAND     = 1100;
  localparam int IdleLimit = 20000;
  localparam int Latency   = 60;

  typedef struct {
    logic signed [15:0] v [9];
    bit                 known;
    logic        [55:0] res;
  } tri_row_t;

  // same bit order as the result tdata, lowest field last
  typedef struct packed {
    logic               degen;
    logic signed [15:0] nz;
    logic signed [15:0] ny;
    logic signed [15:0] nx;
  } normal_t;

  logic         clk;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [15:0]  cfg_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [55:0]  m_axis_tdata;

  logic [15:0]  min_len_q;
  normal_t      normal_q [$];
  int           send_idle_pct;
  int           recv_idle_pct;
  bit           recv_hold;
  int           n_bad;
  int           n_seen;
  int           n_degen;
  int           idle_cycles;

  triangle_face_normal_unit_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // exact face normal of one triangle
  function automatic normal_t face_normal(logic signed [15:0] v [9], logic [15:0] thr);
    normal_t            r;
    logic signed [63:0] e1 [3];
    logic signed [63:0] e2 [3];
    logic signed [63:0] n [3];
    logic [127:0]       sum;
    logic [127:0]       len;
    logic [127:0]       bitv;
    logic [127:0]       rem;
    logic [127:0]       mag;
    logic [127:0]       q;
    for (int k = 0; k < 3; k++) begin
      e1[k] = 64'(v[3+k]) - 64'(v[k]);
      e2[k] = 64'(v[6+k]) - 64'(v[k]);
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    sum = 0;
    for (int k = 0; k < 3; k++) sum += 128'(n[k] * n[k]);
    // bitwise integer square root
    rem  = sum;
    len  = 0;
    bitv = 128'd1 << 126;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= len + bitv) begin
        rem = rem - (len + bitv);
        len = (len >> 1) + bitv;
      end else begin
        len = len >> 1;
      end
      bitv >>= 2;
    end
    r = '0;
    if (len <= 128'(thr)) begin
      r.degen = 1'b1;
      return r;
    end
    for (int k = 0; k < 3; k++) begin
      mag = 128'(n[k] < 0 ? -n[k] : n[k]);
      q = ((mag << 14) + (len >> 1)) / len;
      if (q > 128'd16384) q = 128'd16384;
      if (n[k] < 0) q = -q;
      if (k == 0) r.nx = q[15:0];
      else if (k == 1) r.ny = q[15:0];
      else r.nz = q[15:0];
    end
    return r;
  endfunction

  function automatic logic [143:0] pack_tri(logic signed [15:0] v [9]);
    logic [143:0] d;
    for (int i = 0; i < 9; i++) d[16*i +: 16] = v[i];
    return d;
  endfunction

  // inputs move on the falling edge
  task automatic write_min_length(logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    min_len_q = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_triangle(logic signed [15:0] v [9], bit known, logic [55:0] res);
    normal_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_tri(v);
    do @(posedge clk); while (!s_axis_tready);
    e = face_normal(v, min_len_q);
    if (known) e = normal_t'(res[48:0]);
    normal_q = {normal_q, e};
  endtask

  task automatic drain;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (normal_q.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  // random triangle: small or wider shapes, sometimes full range or flat
  task automatic random_triangle(output logic signed [15:0] v [9]);
    int mode;
    int span;
    mode = $urandom_range(9);
    span = (mode < 5) ? 255 : 4095;
    for (int i = 0; i < 9; i++) begin
      if (mode >= 8) v[i] = 16'($urandom);
      else if (i < 3) v[i] = 16'($urandom);
      else v[i] = v[i % 3] + $signed(16'($urandom_range(2 * span) - span));
    end
    // collinear or coincident vertices
    if (mode == 7) for (int i = 0; i < 3; i++) v[6+i] = v[3+i];
  endtask

  // result checker
  always @(posedge clk) begin
    normal_t got;
    normal_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = normal_t'(m_axis_tdata[48:0]);
      n_seen++;
      if (got.degen) n_degen++;
      if (normal_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        want = normal_q.pop_front();
        if (got !== want || m_axis_tdata[55:49] !== 7'd0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: expected %0d %0d %0d d%0b, got %0d %0d %0d d%0b",
                     want.nx, want.ny, want.nz, want.degen,
                     got.nx, got.ny, got.nz, got.degen);
        end
      end
    end
  end

  // receiver readiness, with one long hold-off
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    recv_hold = 1'b0;
    wait (rst === 1'b0);
    repeat (300) @(posedge clk);
    recv_hold = 1'b1;
    repeat (400) @(posedge clk);
    recv_hold = 1'b0;
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    tri_row_t                 dir [NDIR];
    logic signed [15:0]       v [9];
    logic [15:0]              thr_set [4];
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    min_len_q     = '0;
    n_bad = 0; n_seen = 0; n_degen = 0; idle_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // directed table: known rows carry the expected normal
    foreach (dir[r]) begin
      dir[r].known = 1'b0;
      dir[r].res   = '0;
      foreach (dir[r].v[i]) dir[r].v[i] = 16'sd0;
    end
    // all coincident: degenerate
    dir[0].known = 1'b1; dir[0].res = 56'd1 << 48;
    // unit right triangle in xy plane: +z
    dir[1].v = '{0, 0, 0, 256, 0, 0, 0, 256, 0};
    dir[1].known = 1'b1; dir[1].res = 56'(16384) << 32;
    // reversed winding: -z
    dir[2].v = '{0, 0, 0, 0, 256, 0, 256, 0, 0};
    dir[2].known = 1'b1; dir[2].res = 56'(16'hc000) << 32;
    // yz plane: +x
    dir[3].v = '{0, 0, 0, 0, 256, 0, 0, 0, 256};
    dir[3].known = 1'b1; dir[3].res = 56'(16384);
    // zx plane: +y
    dir[4].v = '{0, 0, 0, 0, 0, 256, 256, 0, 0};
    dir[4].known = 1'b1; dir[4].res = 56'(16384) << 16;
    // widest edges, coordinate extremes
    dir[5].v = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768};
    dir[6].v = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767};
    dir[7].v = '{-32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767, -32768};
    // smallest nonzero cross product
    dir[8].v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    // collinear vertices
    dir[9].v = '{1, 2, 3, 5, 6, 7, 9, 10, 11};
    dir[9].known = 1'b1; dir[9].res = 56'd1 << 48;
    // diagonal normals, rounding
    dir[10].v = '{0, 0, 0, 256, -256, 0, 0, 256, -256};
    dir[11].v = '{100, -200, 300, -7, 55, 1000, 12, -999, 3};
    dir[12].v = '{-1, -1, -1, -32768, 32767, 0, 32767, 0, -32768};
    dir[13].v = '{0, 0, 0, 3, 1, 0, 1, 2, 0};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_min_length(16'd0);
    foreach (dir[r]) send_triangle(dir[r].v, dir[r].known, dir[r].res);
    drain();

    // threshold extremes and edges
    thr_set = '{16'hffff, 16'd5, 16'd0, 16'd1000};
    for (int p = 0; p < 4; p++) begin
      write_min_length(thr_set[p]);
      // cross product lengths of exactly 5 and 6 straddle the small threshold
      v = '{0, 0, 0, 1, 0, 0, 0, 5, 0};
      send_triangle(v, 1'b0, '0);
      v = '{0, 0, 0, 3, 0, 0, 0, 2, 0};
      send_triangle(v, 1'b0, '0);
      for (int i = 0; i < NRAND / 4; i++) begin
        if (i < NRAND / 12) begin
          send_idle_pct = 9; recv_idle_pct = 47;
        end else if (i < NRAND / 6) begin
          send_idle_pct = 47; recv_idle_pct = 9;
        end else begin
          send_idle_pct = 0; recv_idle_pct = 0;
        end
        random_triangle(v);
        send_triangle(v, 1'b0, '0);
      end
      drain();
    end

    $display("checked %0d normals (%0d degenerate) over %0d threshold settings",
             n_seen, n_degen, 5);
    if (n_bad == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
